>>> hw/rtl/laser_frame_stream_decoder_top_macros.svh
// Assertion macros for the laser frame stream decoder.
`ifndef LASER_FRAME_STREAM_DECODER_TOP_MACROS_SVH
`define LASER_FRAME_STREAM_DECODER_TOP_MACROS_SVH
`ifndef SYNTH
`define LFSD_ASSERT_CLK(label, clock, reset_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) prop) else $error(msg);
`define LFSD_ASSERT(label, prop, msg) \
	`LFSD_ASSERT_CLK(label, clk, arst_n, prop, msg)
`else
`define LFSD_ASSERT_CLK(label, clock, reset_n, prop, msg)
`define LFSD_ASSERT(label, prop, msg)
`endif
`endif

>>> hw/rtl/lfsd_pkg.sv
// Shared types, constants and tables of the laser frame stream decoder.
package lfsd_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int STD_ENTRIES     = 64;
	localparam int STD_AW          = $clog2(STD_ENTRIES);
	localparam int HEADER_BYTES    = 32;
	localparam int REC_MAX         = 10;
	localparam int BLANK_BIT       = 6;
	localparam logic [15:0] OFFSET_BIN = 16'h8000;

	typedef enum logic [2:0] {
		FMT_3D_IDX  = 3'd0,
		FMT_2D_IDX  = 3'd1,
		FMT_PALETTE = 3'd2,
		FMT_3D_TRUE = 3'd4,
		FMT_2D_TRUE = 3'd5
	} fmt_t;

	typedef enum logic {
		KIND_POINT      = 1'b0,
		KIND_BAD_HEADER = 1'b1
	} kind_t;

	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr;
		logic [23:0]       data;
	} pal_wr_t;

	typedef struct packed {
		logic       en;
		logic [7:0] idx;
	} pal_rd_t;

	function automatic logic [3:0] rec_len(input fmt_t f);
		logic [3:0] n;
		unique case (f)
			FMT_3D_IDX:  n = 4'd8;
			FMT_2D_IDX:  n = 4'd6;
			FMT_PALETTE: n = 4'd3;
			FMT_3D_TRUE: n = 4'd10;
			FMT_2D_TRUE: n = 4'd8;
			default:     n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] magic_byte(input logic [1:0] i);
		logic [7:0] c;
		unique case (i)
			2'd0: c = 8'h49;
			2'd1: c = 8'h4C;
			2'd2: c = 8'h44;
			default: c = 8'h41;
		endcase
		return c;
	endfunction

	// Standard 64-colour palette, 0xRRGGBB
	function automatic logic [23:0] std_palette(input logic [STD_AW-1:0] i);
		logic [23:0] c;
		unique case (i)
			6'd0:  c = 24'hFF0000; 6'd1:  c = 24'hFF1000; 6'd2:  c = 24'hFF2000;
			6'd3:  c = 24'hFF3000; 6'd4:  c = 24'hFF4000; 6'd5:  c = 24'hFF5000;
			6'd6:  c = 24'hFF6000; 6'd7:  c = 24'hFF7000; 6'd8:  c = 24'hFF8000;
			6'd9:  c = 24'hFF9000; 6'd10: c = 24'hFFA000; 6'd11: c = 24'hFFB000;
			6'd12: c = 24'hFFC000; 6'd13: c = 24'hFFD000; 6'd14: c = 24'hFFE000;
			6'd15: c = 24'hFFF000; 6'd16: c = 24'hFFFF00; 6'd17: c = 24'hE0FF00;
			6'd18: c = 24'hC0FF00; 6'd19: c = 24'hA0FF00; 6'd20: c = 24'h80FF00;
			6'd21: c = 24'h60FF00; 6'd22: c = 24'h40FF00; 6'd23: c = 24'h20FF00;
			6'd24: c = 24'h00FF00; 6'd25: c = 24'h00FF24; 6'd26: c = 24'h00FF49;
			6'd27: c = 24'h00FF6D; 6'd28: c = 24'h00FF92; 6'd29: c = 24'h00FFB6;
			6'd30: c = 24'h00FFDB; 6'd31: c = 24'h00FFFF; 6'd32: c = 24'h00E3FF;
			6'd33: c = 24'h00C6FF; 6'd34: c = 24'h00AAFF; 6'd35: c = 24'h008EFF;
			6'd36: c = 24'h0071FF; 6'd37: c = 24'h0055FF; 6'd38: c = 24'h0038FF;
			6'd39: c = 24'h001CFF; 6'd40: c = 24'h0000FF; 6'd41: c = 24'h2000FF;
			6'd42: c = 24'h4000FF; 6'd43: c = 24'h6000FF; 6'd44: c = 24'h8000FF;
			6'd45: c = 24'hA000FF; 6'd46: c = 24'hC000FF; 6'd47: c = 24'hE000FF;
			6'd48: c = 24'hFF00FF; 6'd49: c = 24'hFF20FF; 6'd50: c = 24'hFF40FF;
			6'd51: c = 24'hFF60FF; 6'd52: c = 24'hFF80FF; 6'd53: c = 24'hFFA0FF;
			6'd54: c = 24'hFFC0FF; 6'd55: c = 24'hFFE0FF; 6'd56: c = 24'hFFFFFF;
			6'd57: c = 24'hFFE0E0; 6'd58: c = 24'hFFC0C0; 6'd59: c = 24'hFFA0A0;
			6'd60: c = 24'hFF8080; 6'd61: c = 24'hFF6060; 6'd62: c = 24'hFF4040;
			default: c = 24'hFF2020;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/lfsd_palette.sv
// Colour palette memory with per-entry valid bits and default table fallback.
module lfsd_palette
	import lfsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  pal_wr_t     wr,
	input  pal_rd_t     rd,
	output logic [23:0] colour
);

	logic [23:0]       mem [PALETTE_ENTRIES];
	logic [23:0]       rd_data_q;
	logic [PALETTE_ENTRIES-1:0] written_q;
	logic              rd_written_q;
	logic              rd_range_q;
	logic [7:0]        rd_idx_q;
	logic              rd_in_range;

	assign rd_in_range = ({1'b0, rd.idx} < 9'(PALETTE_ENTRIES));

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.idx[PAL_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
			rd_range_q   <= 1'b0;
			rd_idx_q     <= '0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_written_q <= written_q[rd.idx[PAL_AW-1:0]];
				rd_range_q   <= rd_in_range;
				rd_idx_q     <= rd.idx;
			end
		end
	end

	// Unwritten entries read as the standard table, or black above it
	always_comb begin
		if (!rd_range_q) begin
			colour = '0;
		end else if (rd_written_q) begin
			colour = rd_data_q;
		end else if (rd_idx_q < 8'(STD_ENTRIES)) begin
			colour = std_palette(rd_idx_q[STD_AW-1:0]);
		end else begin
			colour = '0;
		end
	end

endmodule

>>> hw/rtl/laser_frame_stream_decoder_top.sv
// Top level of the laser frame stream decoder: header parser, record assembly, point output.
//
//  channel  | direction | tdata                          | tuser       | tlast
//  s_axis   | in        | [7:0] in_byte                  | -           | end_of_file
//  m_axis   | out       | x,y,r,g,b,blanked,frame_index  | result_kind | last_in_frame
//
// One byte is taken every cycle while the input is not stalled; after the transfer of
// its final record byte, a point is registered in s1 (decode and palette read), then in
// the output register (colour select). Reset clears parser state; palette entries
// below 64 read as the standard table, the rest as black, until written. A stalled
// output holds the output register, then s1; the input stalls only while both are full.
`include "laser_frame_stream_decoder_top_macros.svh"
module laser_frame_stream_decoder_top
	import lfsd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
	input  logic         s_axis_tlast,   // end_of_file
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [15:0] x_pos, [31:16] y_pos, [47:32] red_level, [63:48] green_level,
	// [79:64] blue_level, [80] blanked, [96:81] frame_index, [103:97] zero
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tuser,   // [0] result_kind
	output logic         m_axis_tlast    // last_in_frame
);

	// Parser state
	logic        in_header_q;
	logic [4:0]  pos_q;
	logic        magic_ok_q;
	fmt_t        fmt_q;
	logic [15:0] total_q;
	logic [15:0] index_q;
	logic [7:0]  rec_q [REC_MAX];
	logic [15:0] section_q;

	logic        in_header_nxt;
	logic [4:0]  pos_nxt;
	logic        magic_ok_nxt;
	fmt_t        fmt_nxt;
	logic [15:0] total_nxt;
	logic [15:0] index_nxt;
	logic [15:0] section_nxt;

	logic        accept;
	logic        advance;
	logic [7:0]  b;
	logic [7:0]  rb [REC_MAX];
	logic [3:0]  len;
	logic        rec_done;
	logic        emit;
	kind_t       kind;
	logic [15:0] x_val;
	logic [15:0] y_val;
	logic [7:0]  status;
	logic [23:0] true_rgb;
	logic        use_pal;
	logic        last_val;
	pal_wr_t     pal_wr;
	pal_rd_t     pal_rd;
	logic [23:0] pal_colour;

	// s1 stage
	logic        valid_s1;
	kind_t       kind_s1;
	logic [15:0] x_s1;
	logic [15:0] y_s1;
	logic [23:0] rgb_s1;
	logic        use_pal_s1;
	logic        blank_s1;
	logic        last_s1;
	logic [15:0] frame_s1;

	// Output register
	logic        out_valid_q;
	kind_t       kind_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [23:0] colour_q;
	logic        blank_q;
	logic        last_q;
	logic [15:0] frame_q;
	logic [23:0] colour_sel;

	assign b             = s_axis_tdata;
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Record bytes as seen with the current byte merged in
	always_comb begin
		for (int i = 0; i < REC_MAX; i++) begin
			rb[i] = (pos_q == 5'(i)) ? b : rec_q[i];
		end
	end

	always_comb begin
		in_header_nxt = in_header_q;
		pos_nxt       = pos_q;
		magic_ok_nxt  = magic_ok_q;
		fmt_nxt       = fmt_q;
		total_nxt     = total_q;
		index_nxt     = index_q;
		section_nxt   = section_q;
		emit          = 1'b0;
		kind          = KIND_POINT;
		pal_wr        = '0;
		len           = rec_len(fmt_q);
		rec_done      = ({1'b0, pos_q} + 6'd1) >= {2'b00, len};

		x_val    = {rb[0], rb[1]} + OFFSET_BIN;
		y_val    = OFFSET_BIN - {rb[2], rb[3]};
		status   = (fmt_q == FMT_2D_IDX || fmt_q == FMT_2D_TRUE) ? rb[4] : rb[6];
		use_pal  = (fmt_q == FMT_3D_IDX || fmt_q == FMT_2D_IDX);
		true_rgb = (fmt_q == FMT_3D_TRUE) ? {rb[9], rb[8], rb[7]} : {rb[7], rb[6], rb[5]};
		last_val = ({1'b0, index_q} + 17'd1) == {1'b0, total_q};

		if (in_header_q) begin
			if (pos_q < 5'd4 && b != magic_byte(pos_q[1:0])) begin
				magic_ok_nxt = 1'b0;
			end
			if (pos_q == 5'd7) begin
				if (b == 8'(FMT_3D_IDX) || b == 8'(FMT_2D_IDX) || b == 8'(FMT_PALETTE) ||
				    b == 8'(FMT_3D_TRUE) || b == 8'(FMT_2D_TRUE)) begin
					fmt_nxt = fmt_t'(b[2:0]);
				end else begin
					magic_ok_nxt = 1'b0;
				end
			end
			if (pos_q == 5'd24) begin
				total_nxt = {b, 8'h00};
			end
			if (pos_q == 5'd25) begin
				total_nxt = {total_q[15:8], b};
			end
			if (pos_q == 5'(HEADER_BYTES - 1)) begin
				pos_nxt = '0;
				if (!magic_ok_nxt) begin
					emit          = 1'b1;
					kind          = KIND_BAD_HEADER;
					magic_ok_nxt  = 1'b1;
					section_nxt   = '0;
				end else if (total_nxt == '0) begin
					section_nxt   = '0;
				end else begin
					in_header_nxt = 1'b0;
					index_nxt     = '0;
				end
			end else begin
				pos_nxt = pos_q + 5'd1;
			end
		end else begin
			if (rec_done) begin
				pos_nxt = '0;
				if (fmt_q == FMT_PALETTE) begin
					pal_wr.en   = (32'(index_q) < PALETTE_ENTRIES);
					pal_wr.addr = index_q[PAL_AW-1:0];
					pal_wr.data = {rb[0], rb[1], rb[2]};
				end else begin
					emit = 1'b1;
				end
				index_nxt = index_q + 16'd1;
				if (index_nxt >= total_q) begin
					in_header_nxt = 1'b1;
					magic_ok_nxt  = 1'b1;
					section_nxt   = section_q + 16'd1;
				end
			end else begin
				pos_nxt = pos_q + 5'd1;
			end
		end

		// End of file: restart at a header after this byte
		if (s_axis_tlast) begin
			in_header_nxt = 1'b1;
			pos_nxt       = '0;
			magic_ok_nxt  = 1'b1;
			section_nxt   = '0;
		end

		pal_wr.en = pal_wr.en && accept;
	end

	assign pal_rd.en  = accept;
	assign pal_rd.idx = use_pal ? (fmt_q == FMT_3D_IDX ? rb[7] : rb[5]) : b;

	lfsd_palette u_palette (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (pal_wr),
		.rd     (pal_rd),
		.colour (pal_colour)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q <= 1'b1;
			pos_q       <= '0;
			magic_ok_q  <= 1'b1;
			fmt_q       <= FMT_3D_IDX;
			total_q     <= '0;
			index_q     <= '0;
			section_q   <= '0;
		end else if (accept) begin
			in_header_q <= in_header_nxt;
			pos_q       <= pos_nxt;
			magic_ok_q  <= magic_ok_nxt;
			fmt_q       <= fmt_nxt;
			total_q     <= total_nxt;
			index_q     <= index_nxt;
			section_q   <= section_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !in_header_q && pos_q < 5'(REC_MAX)) begin
			rec_q[pos_q[3:0]] <= b;
		end
	end

	// s1: decoded point or bad header report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			if (kind == KIND_BAD_HEADER) begin
				x_s1       <= '0;
				y_s1       <= '0;
				rgb_s1     <= '0;
				use_pal_s1 <= 1'b0;
				blank_s1   <= 1'b0;
				last_s1    <= 1'b0;
				frame_s1   <= '0;
			end else begin
				x_s1       <= x_val;
				y_s1       <= y_val;
				rgb_s1     <= true_rgb;
				use_pal_s1 <= use_pal;
				blank_s1   <= status[BLANK_BIT];
				last_s1    <= last_val;
				frame_s1   <= section_q;
			end
		end
	end

	// Blanking forces black
	always_comb begin
		if (blank_s1) begin
			colour_sel = '0;
		end else if (use_pal_s1) begin
			colour_sel = pal_colour;
		end else begin
			colour_sel = rgb_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			kind_q   <= kind_s1;
			x_q      <= x_s1;
			y_q      <= y_s1;
			colour_q <= colour_sel;
			blank_q  <= blank_s1;
			last_q   <= last_s1;
			frame_q  <= frame_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {7'b0, frame_q, blank_q,
		colour_q[7:0], colour_q[7:0],
		colour_q[15:8], colour_q[15:8],
		colour_q[23:16], colour_q[23:16],
		y_q, x_q};

	`LFSD_ASSERT(a_bad_header_clean, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast, "bad header result carries payload")
	`LFSD_ASSERT(a_blank_black, m_axis_tvalid && m_axis_tdata[80] |-> m_axis_tdata[79:32] == '0, "blanked point is not black")
	`LFSD_ASSERT(a_stall_only_when_full, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && valid_s1, "input stalled with room in pipeline")
	`LFSD_ASSERT(a_record_pos_bound, !in_header_q |-> pos_q < 5'(REC_MAX), "record byte position out of range")

endmodule

>>> tb/sv/laser_decode_tb_pkg.sv
// Point scoreboard and expected-result calculation for the laser frame stream decoder bench.
`timescale 1ns / 100ps
package laser_decode_tb_pkg;
	import lfsd_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] x_pos;
		logic [15:0] y_pos;
		logic [15:0] red_level;
		logic [15:0] green_level;
		logic [15:0] blue_level;
		logic        blanked;
		logic        last_in_frame;
		logic [15:0] frame_index;
	} point_result_t;

	localparam logic [7:0] ILDA_MAGIC [4] = '{8'h49, 8'h4C, 8'h44, 8'h41};

	// Colours that a fresh palette holds in its first 64 entries, 0xRRGGBB
	localparam logic [23:0] DEFAULT_COLOURS [64] = '{
		24'hFF0000, 24'hFF1000, 24'hFF2000, 24'hFF3000, 24'hFF4000, 24'hFF5000, 24'hFF6000,
		24'hFF7000, 24'hFF8000, 24'hFF9000, 24'hFFA000, 24'hFFB000, 24'hFFC000, 24'hFFD000,
		24'hFFE000, 24'hFFF000, 24'hFFFF00, 24'hE0FF00, 24'hC0FF00, 24'hA0FF00, 24'h80FF00,
		24'h60FF00, 24'h40FF00, 24'h20FF00, 24'h00FF00, 24'h00FF24, 24'h00FF49, 24'h00FF6D,
		24'h00FF92, 24'h00FFB6, 24'h00FFDB, 24'h00FFFF, 24'h00E3FF, 24'h00C6FF, 24'h00AAFF,
		24'h008EFF, 24'h0071FF, 24'h0055FF, 24'h0038FF, 24'h001CFF, 24'h0000FF, 24'h2000FF,
		24'h4000FF, 24'h6000FF, 24'h8000FF, 24'hA000FF, 24'hC000FF, 24'hE000FF, 24'hFF00FF,
		24'hFF20FF, 24'hFF40FF, 24'hFF60FF, 24'hFF80FF, 24'hFFA0FF, 24'hFFC0FF, 24'hFFE0FF,
		24'hFFFFFF, 24'hFFE0E0, 24'hFFC0C0, 24'hFFA0A0, 24'hFF8080, 24'hFF6060, 24'hFF4040,
		24'hFF2020
	};

	class point_scoreboard;
		logic          in_hdr;
		logic [4:0]    pos;
		logic          hdr_ok;
		fmt_t          fmt;
		logic [15:0]   rec_total;
		logic [15:0]   rec_idx;
		logic [7:0]    rec_buf [REC_MAX];
		logic [23:0]   colour_lut [PALETTE_ENTRIES];
		logic [15:0]   sections;
		point_result_t pending_points [$];
		int            failures;

		function new();
			in_hdr    = 1'b1;
			pos       = '0;
			hdr_ok    = 1'b1;
			fmt       = FMT_3D_IDX;
			rec_total = '0;
			rec_idx   = '0;
			sections  = '0;
			failures  = 0;
			foreach (rec_buf[i])
				rec_buf[i] = '0;
			foreach (colour_lut[i])
				colour_lut[i] = (i < 64) ? DEFAULT_COLOURS[i] : 24'h000000;
		endfunction

		function int pending();
			return pending_points.size();
		endfunction

		function void restart_parse();
			in_hdr   = 1'b1;
			pos      = '0;
			hdr_ok   = 1'b1;
			sections = '0;
		endfunction

		function int record_length(fmt_t f);
			case (f)
				FMT_3D_IDX:  return 8;
				FMT_2D_IDX:  return 6;
				FMT_PALETTE: return 3;
				FMT_3D_TRUE: return 10;
				FMT_2D_TRUE: return 8;
				default:     return 0;
			endcase
		endfunction

		function void decode_record();
			point_result_t res;
			logic [15:0]   x;
			logic [15:0]   y;
			logic [23:0]   rgb;
			logic [7:0]    status;
			int            p;
			if (fmt == FMT_PALETTE) begin
				// entries past the end of the palette are dropped
				if (rec_idx < PALETTE_ENTRIES)
					colour_lut[rec_idx] = {rec_buf[0], rec_buf[1], rec_buf[2]};
				return;
			end
			x      = {rec_buf[0], rec_buf[1]};
			y      = {rec_buf[2], rec_buf[3]};
			p      = (fmt == FMT_3D_IDX || fmt == FMT_3D_TRUE) ? 6 : 4;
			status = rec_buf[p];
			rgb    = '0;
			if (fmt == FMT_3D_IDX || fmt == FMT_2D_IDX) begin
				if (rec_buf[p + 1] < PALETTE_ENTRIES)
					rgb = colour_lut[rec_buf[p + 1]];
			end else begin
				// true colour arrives as blue, green, red
				rgb = {rec_buf[p + 3], rec_buf[p + 2], rec_buf[p + 1]};
			end
			if (status[BLANK_BIT])
				rgb = '0;
			res               = '0;
			res.kind          = KIND_POINT;
			res.x_pos         = x + OFFSET_BIN;
			res.y_pos         = OFFSET_BIN - y;
			res.red_level     = {2{rgb[23:16]}};
			res.green_level   = {2{rgb[15:8]}};
			res.blue_level    = {2{rgb[7:0]}};
			res.blanked       = status[BLANK_BIT];
			res.last_in_frame = ({1'b0, rec_idx} + 17'd1) == {1'b0, rec_total};
			res.frame_index   = sections;
			pending_points.push_back(res);
		endfunction

		// Advance the parser by one accepted byte and queue any point it produces
		function void note_byte(logic [7:0] b, logic eof);
			point_result_t res;
			int            len;
			if (in_hdr) begin
				if (pos < 4 && b != ILDA_MAGIC[pos[1:0]])
					hdr_ok = 1'b0;
				if (pos == 7) begin
					if (b[7:3] == 5'd0 && (b[2:0] inside {FMT_3D_IDX, FMT_2D_IDX, FMT_PALETTE,
							FMT_3D_TRUE, FMT_2D_TRUE}))
						fmt = fmt_t'(b[2:0]);
					else
						hdr_ok = 1'b0;
				end
				if (pos == 24)
					rec_total = {b, 8'h00};
				if (pos == 25)
					rec_total[7:0] = b;
				if (pos == HEADER_BYTES - 1) begin
					pos = '0;
					if (!hdr_ok) begin
						res      = '0;
						res.kind = KIND_BAD_HEADER;
						pending_points.push_back(res);
						restart_parse();
					end else if (rec_total == 16'd0) begin
						restart_parse();
					end else begin
						in_hdr  = 1'b0;
						rec_idx = '0;
					end
				end else begin
					pos = pos + 5'd1;
				end
			end else begin
				len = record_length(fmt);
				rec_buf[pos] = b;
				if (pos + 1 >= len) begin
					pos = '0;
					decode_record();
					rec_idx = rec_idx + 16'd1;
					if (rec_idx >= rec_total) begin
						in_hdr   = 1'b1;
						hdr_ok   = 1'b1;
						sections = sections + 16'd1;
					end
				end else begin
					pos = pos + 5'd1;
				end
			end
			if (eof)
				restart_parse();
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%h, got 0x%h", field, want, got);
				failures++;
			end
		endfunction

		function void check_point(point_result_t got);
			point_result_t want;
			if (pending_points.size() == 0) begin
				$error("output transfer with nothing expected: kind %0d x_pos 0x%h y_pos 0x%h",
					got.kind, got.x_pos, got.y_pos);
				failures++;
				return;
			end
			want = pending_points.pop_front();
			compare_field("result_kind", 16'(want.kind), 16'(got.kind));
			compare_field("x_pos", want.x_pos, got.x_pos);
			compare_field("y_pos", want.y_pos, got.y_pos);
			compare_field("red_level", want.red_level, got.red_level);
			compare_field("green_level", want.green_level, got.green_level);
			compare_field("blue_level", want.blue_level, got.blue_level);
			compare_field("blanked", 16'(want.blanked), 16'(got.blanked));
			compare_field("last_in_frame", 16'(want.last_in_frame), 16'(got.last_in_frame));
			compare_field("frame_index", want.frame_index, got.frame_index);
		endfunction
	endclass

endpackage

>>> tb/sv/tb_laser_frame_stream_decoder_top.sv
// Testbench top for the laser frame stream decoder: directed and random ILDA byte streams.
`timescale 1ns / 100ps
module tb_laser_frame_stream_decoder_top;
	import lfsd_pkg::*;
	import laser_decode_tb_pkg::*;

	localparam int         CLK_HALF     = 6;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         RANDOM_BYTES = 1200;
	localparam int         HOLD_CYCLES  = 400;
	localparam logic [7:0] FMT_UNUSED   = 8'd3;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;

	point_scoreboard sb;
	logic            idle_on;
	logic            counting;
	int              eof_permille;
	int              rx_hold_request;
	int              random_sent;
	int              cycle_count;

	fmt_t valid_fmts [5] = '{FMT_3D_IDX, FMT_2D_IDX, FMT_PALETTE, FMT_3D_TRUE, FMT_2D_TRUE};

	laser_frame_stream_decoder_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		point_result_t got;
		if (arst_n === 1'b1) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind          = kind_t'(m_axis_tuser);
				got.x_pos         = m_axis_tdata[15:0];
				got.y_pos         = m_axis_tdata[31:16];
				got.red_level     = m_axis_tdata[47:32];
				got.green_level   = m_axis_tdata[63:48];
				got.blue_level    = m_axis_tdata[79:64];
				got.blanked       = m_axis_tdata[80];
				got.frame_index   = m_axis_tdata[96:81];
				got.last_in_frame = m_axis_tlast;
				sb.check_point(got);
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_request != 0) begin
				hold_left       = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	function automatic logic roll_eof();
		return $urandom_range(0, 999) < eof_permille;
	endfunction

	// Offer one byte and hold it until the transfer happens
	task automatic send_byte(input logic [7:0] b, input logic eof);
		while (idle_on && $urandom_range(0, 99) < 16) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eof;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
		if (counting)
			random_sent++;
	endtask

	// bad_pos selects a magic byte to corrupt; -1 keeps the magic intact
	task automatic send_header(input logic [7:0] fmt_byte, input logic [15:0] count,
			input int bad_pos);
		logic [7:0] b;
		for (int i = 0; i < HEADER_BYTES; i++) begin
			case (i)
				0, 1, 2, 3: b = ILDA_MAGIC[i] ^ ((i == bad_pos) ? 8'($urandom_range(1, 255)) : 8'h00);
				7:          b = fmt_byte;
				24:         b = count[15:8];
				25:         b = count[7:0];
				default:    b = 8'($urandom);
			endcase
			send_byte(b, roll_eof());
		end
	endtask

	// colour holds the palette index in its low byte, or {red, green, blue} for true colour
	task automatic send_point(input fmt_t f, input logic [15:0] x, input logic [15:0] y,
			input logic [7:0] status, input logic [23:0] colour, input logic eof_last);
		logic [7:0] rec [REC_MAX];
		int         n;
		rec[0] = x[15:8];
		rec[1] = x[7:0];
		rec[2] = y[15:8];
		rec[3] = y[7:0];
		n      = 4;
		if (f == FMT_3D_IDX || f == FMT_3D_TRUE) begin
			rec[4] = 8'($urandom);
			rec[5] = 8'($urandom);
			n      = 6;
		end
		rec[n]     = status;
		rec[n + 1] = colour[7:0];
		if (f == FMT_3D_IDX || f == FMT_2D_IDX) begin
			n += 2;
		end else begin
			rec[n + 2] = colour[15:8];
			rec[n + 3] = colour[23:16];
			n += 4;
		end
		for (int i = 0; i < n; i++)
			send_byte(rec[i], (i == n - 1) ? (eof_last | roll_eof()) : roll_eof());
	endtask

	task automatic send_palette(input logic [23:0] rgb, input logic eof_last);
		send_byte(rgb[23:16], roll_eof());
		send_byte(rgb[15:8], roll_eof());
		send_byte(rgb[7:0], eof_last | roll_eof());
	endtask

	task automatic send_section(input fmt_t f, input int count, input logic eof_end);
		send_header(8'(f), 16'(count), -1);
		for (int i = 0; i < count; i++) begin
			if (f == FMT_PALETTE)
				send_palette(24'($urandom), eof_end && i == count - 1);
			else
				send_point(f, 16'($urandom), 16'($urandom), 8'($urandom), 24'($urandom),
					eof_end && i == count - 1);
		end
	endtask

	task automatic drain_points();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int         pick;
		int         n;
		logic       held;
		logic       paused;
		logic [7:0] bad_fmt;
		sb              = new();
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = 8'h00;
		s_axis_tlast    = 1'b0;
		idle_on         = 1'b1;
		counting        = 1'b0;
		eof_permille    = 0;
		rx_hold_request = 0;
		random_sent     = 0;
		cycle_count     = 0;
		held            = 1'b0;
		paused          = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// every point format, coordinate extremes, blanking and the default palette
		send_header(8'(FMT_3D_IDX), 16'd3, -1);
		send_point(FMT_3D_IDX, 16'h0000, 16'h0000, 8'h00, 24'd0, 1'b0);
		send_point(FMT_3D_IDX, 16'hFFFF, 16'h8000, 8'hBF, 24'd255, 1'b0);
		send_point(FMT_3D_IDX, 16'h7FFF, 16'h7FFF, 8'h40, 24'd63, 1'b0);
		send_header(8'(FMT_2D_IDX), 16'd2, -1);
		send_point(FMT_2D_IDX, 16'h8000, 16'hFFFF, 8'h00, 24'd17, 1'b0);
		send_point(FMT_2D_IDX, 16'h1234, 16'h0001, 8'hFF, 24'd40, 1'b0);
		send_header(8'(FMT_3D_TRUE), 16'd2, -1);
		send_point(FMT_3D_TRUE, 16'h8001, 16'h7FFE, 8'h00, 24'hFF0080, 1'b0);
		send_point(FMT_3D_TRUE, 16'hC000, 16'h4000, 8'h40, 24'hFFFFFF, 1'b0);
		send_header(8'(FMT_2D_TRUE), 16'd1, -1);
		send_point(FMT_2D_TRUE, 16'h0100, 16'hFF00, 8'h80, 24'h00FF01, 1'b0);
		// load two palette entries, then look them up; end of file on the last point
		send_header(8'(FMT_PALETTE), 16'd2, -1);
		send_palette(24'h123456, 1'b0);
		send_palette(24'hABCDEF, 1'b0);
		send_header(8'(FMT_2D_IDX), 16'd2, -1);
		send_point(FMT_2D_IDX, 16'h0000, 16'h0000, 8'h00, 24'd0, 1'b0);
		send_point(FMT_2D_IDX, 16'hFFFF, 16'hFFFF, 8'h00, 24'd1, 1'b1);
		// empty section, corrupt magic in each position, unknown formats
		send_header(8'(FMT_2D_TRUE), 16'd0, -1);
		for (int i = 0; i < 4; i++)
			send_header(8'(FMT_3D_IDX), 16'd1, i);
		send_header(FMT_UNUSED, 16'd1, -1);
		send_header(8'd6, 16'd1, -1);
		send_header(8'hFF, 16'd1, -1);
		// end of file inside a record, then inside a header
		send_header(8'(FMT_3D_TRUE), 16'd3, -1);
		for (int i = 0; i < 4; i++)
			send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b1);
		for (int i = 0; i < 9; i++)
			send_byte(ILDA_MAGIC[i % 4], 1'b0);
		send_byte(8'h00, 1'b1);
		// more palette records than entries, then read the top of the palette
		send_section(FMT_PALETTE, 258, 1'b0);
		send_header(8'(FMT_3D_IDX), 16'd2, -1);
		send_point(FMT_3D_IDX, 16'h5555, 16'hAAAA, 8'h00, 24'd255, 1'b0);
		send_point(FMT_3D_IDX, 16'hAAAA, 16'h5555, 8'h00, 24'd128, 1'b0);

		counting     = 1'b1;
		eof_permille = 3;
		while (random_sent < RANDOM_BYTES) begin
			if (!held && random_sent >= 300) begin
				held            = 1'b1;
				rx_hold_request = HOLD_CYCLES;
			end
			if (!paused && random_sent >= 550) begin
				paused = 1'b1;
				drain_points();
			end
			idle_on = !(random_sent >= 700 && random_sent < 950);
			pick    = $urandom_range(0, 99);
			if (pick < 75) begin
				n = $urandom_range(1, 6);
				send_section(valid_fmts[$urandom_range(0, 4)], n, $urandom_range(0, 99) < 8);
			end else if (pick < 83) begin
				if ($urandom_range(0, 1)) begin
					send_header(8'(valid_fmts[$urandom_range(0, 4)]), 16'($urandom_range(1, 6)),
						$urandom_range(0, 3));
				end else begin
					bad_fmt = $urandom_range(0, 1) ? 8'($urandom_range(6, 255)) : FMT_UNUSED;
					send_header(bad_fmt, 16'($urandom_range(0, 6)), -1);
				end
			end else if (pick < 90) begin
				send_header(8'(valid_fmts[$urandom_range(0, 4)]), 16'd0, -1);
			end else begin
				// stray bytes, then end of file to resynchronise
				n = $urandom_range(1, 40);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom), 1'b0);
				send_byte(8'($urandom), 1'b1);
			end
		end

		s_axis_tvalid <= 1'b0;
		counting = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (sb.failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
